// ===== hdl/iaf_pkg.sv =====
// ----------------------------------------------------------------------------
// iaf_pkg
// Shared types, constants and helpers for the integer to ascii formatter.
// ----------------------------------------------------------------------------
package iaf_pkg;

    // format request codes
    localparam logic [1:0] REQ_DEC = 2'd0;
    localparam logic [1:0] REQ_HEX = 2'd1;
    localparam logic [1:0] REQ_PTR = 2'd2;

    // field widths
    localparam int REQ_W    = 2;
    localparam int VALUE_W  = 64;
    localparam int CHAR_W   = 8;
    localparam int COUNT_W  = 5;
    localparam int IN_TDATA_W  = ((REQ_W + VALUE_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((CHAR_W + COUNT_W + 7) / 8) * 8;

    // decimal conversion sizes
    localparam int DEC_BIN_W  = 32;
    localparam int DEC_DIGITS = 10;
    localparam int BCD_W      = DEC_DIGITS * 4;
    localparam int HEX_DIGITS = VALUE_W / 4;
    localparam int NDIG_W     = 5;

    // ascii codes used for prefixes
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;
    localparam logic [CHAR_W-1:0] CH_X     = 8'd120;

    // status of the shift-and-add-3 converter
    typedef struct packed {
        logic busy;
        logic done;
    } iaf_dabble_stat_t;

    // one hex or bcd digit to its lower-case ascii code
    function automatic logic [CHAR_W-1:0] nibble_to_ascii(input logic [3:0] nib);
        logic [CHAR_W-1:0] res;
        if (nib < 4'd10)
        begin
            res = CH_ZERO + {4'd0, nib};
        end
        else
        begin
            res = 8'd87 + {4'd0, nib};
        end
        return res;
    endfunction

endpackage

// ===== hdl/iaf_dabble.sv =====
// ----------------------------------------------------------------------------
// iaf_dabble
// Iterative binary to bcd converter: one shift-and-add-3 step per cycle.
// ----------------------------------------------------------------------------
module iaf_dabble (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [iaf_pkg::DEC_BIN_W-1:0]     bin,
    output iaf_pkg::iaf_dabble_stat_t         stat,
    output logic [iaf_pkg::BCD_W-1:0]         bcd
);
    import iaf_pkg::*;

    localparam int CNT_W = $clog2(DEC_BIN_W + 1);

    logic [DEC_BIN_W-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0]     bcd_reg, bcd_next;
    logic [BCD_W-1:0]     adj;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    // add 3 to every digit of 5 or more
    always_comb
    begin
        for (int d = 0; d < DEC_DIGITS; d++)
        begin
            if (bcd_reg[d*4 +: 4] >= 4'd5)
            begin
                adj[d*4 +: 4] = bcd_reg[d*4 +: 4] + 4'd3;
            end
            else
            begin
                adj[d*4 +: 4] = bcd_reg[d*4 +: 4];
            end
        end
    end

    // step sequencing
    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            bin_next  = bin;
            bcd_next  = '0;
            cnt_next  = CNT_W'(DEC_BIN_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            bcd_next = {adj[BCD_W-2:0], bin_reg[DEC_BIN_W-1]};
            bin_next = {bin_reg[DEC_BIN_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign bcd       = bcd_reg;

    // step count stays in range and is zero when idle
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEC_BIN_W))
        else $error("dabble step count out of range");

    a_idle_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> cnt_reg == '0)
        else $error("dabble idle with steps left");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("dabble done without a conversion");

endmodule

// ===== hdl/integer_to_ascii_formatter_top.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_top
// Formats one value as signed decimal, hex or 0x-prefixed hex, one ascii
// character per output transaction, most significant first.
// ----------------------------------------------------------------------------
// Flow: decimal passes through the bcd converter, then skips leading zeros
//   one per cycle (up to 9) before emitting; hex and pointer go straight to
//   skipping leading zeros and then emit from the output register.
// Throughput: one item at a time; characters leave at one per cycle while
//   the output is not stalled, and input reopens once the last one is taken.
// Reset: rst_n clears the sequencer, converter and output valid; no item
//   is in flight afterwards and the block is ready at once.
module integer_to_ascii_formatter_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // req_type[1:0], value[65:2], zero pad
    input  logic [iaf_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // char_code[7:0], char_count[12:8], zero pad
    output logic [iaf_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // last_char
    output logic                             m_axis_tlast
);
    import iaf_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_TRIM,
        ST_EMIT
    } state_t;

    state_t                state_reg, state_next;
    logic [VALUE_W-1:0]    digits_reg, digits_next;
    logic [NDIG_W-1:0]     ndig_reg, ndig_next;
    logic [2*CHAR_W-1:0]   pre_reg, pre_next;
    logic [1:0]            pre_n_reg, pre_n_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic                  ovalid_reg, ovalid_next;
    logic [CHAR_W-1:0]     ochar_reg, ochar_next;
    logic                  olast_reg, olast_next;

    logic [REQ_W-1:0]      in_req;
    logic [VALUE_W-1:0]    in_value;
    logic [DEC_BIN_W-1:0]  low, mag;
    logic                  accept;
    logic                  out_free;
    logic                  dab_start;
    iaf_dabble_stat_t      dab_stat;
    logic [BCD_W-1:0]      dab_bcd;

    // input unpacking and magnitude of the decimal operand
    assign in_req   = s_axis_tdata[REQ_W-1:0];
    assign in_value = s_axis_tdata[REQ_W +: VALUE_W];
    assign low      = in_value[DEC_BIN_W-1:0];
    assign mag      = low[DEC_BIN_W-1] ? (~low + 1'b1) : low;

    // new item only once the previous run's last character has left
    assign s_axis_tready = (state_reg == ST_IDLE) && !ovalid_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !ovalid_reg || m_axis_tready;
    assign dab_start     = accept && (in_req == REQ_DEC);

    iaf_dabble u_dabble (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dab_start),
        .bin   (mag),
        .stat  (dab_stat),
        .bcd   (dab_bcd)
    );

    // sequencer: capture, convert, skip leading zeros, emit
    always_comb
    begin
        state_next  = state_reg;
        digits_next = digits_reg;
        ndig_next   = ndig_reg;
        pre_next    = pre_reg;
        pre_n_next  = pre_n_reg;
        count_next  = count_reg;
        ovalid_next = ovalid_reg;
        ochar_next  = ochar_reg;
        olast_next  = olast_reg;

        // output register drains on a transaction
        if (ovalid_reg && m_axis_tready)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    count_next = '0;
                    unique case (in_req)
                        REQ_DEC:
                        begin
                            pre_next   = {CH_MINUS, CH_ZERO};
                            pre_n_next = low[DEC_BIN_W-1] ? 2'd1 : 2'd0;
                            state_next = ST_CONV;
                        end
                        REQ_HEX:
                        begin
                            digits_next = in_value;
                            ndig_next   = NDIG_W'(HEX_DIGITS);
                            pre_n_next  = 2'd0;
                            state_next  = ST_TRIM;
                        end
                        REQ_PTR:
                        begin
                            digits_next = in_value;
                            ndig_next   = NDIG_W'(HEX_DIGITS);
                            pre_next    = {CH_ZERO, CH_X};
                            pre_n_next  = 2'd2;
                            state_next  = ST_TRIM;
                        end
                        default:
                        begin
                            // unused format code, nothing to emit
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CONV:
            begin
                if (dab_stat.done)
                begin
                    digits_next = {dab_bcd, {(VALUE_W-BCD_W){1'b0}}};
                    ndig_next   = NDIG_W'(DEC_DIGITS);
                    state_next  = ST_TRIM;
                end
            end
            ST_TRIM:
            begin
                // drop one leading zero digit a cycle, keep at least one
                if (ndig_reg > NDIG_W'(1) && digits_reg[VALUE_W-1 -: 4] == 4'd0)
                begin
                    digits_next = {digits_reg[VALUE_W-5:0], 4'd0};
                    ndig_next   = ndig_reg - 1'b1;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    count_next  = count_reg + 1'b1;
                    if (pre_n_reg != 2'd0)
                    begin
                        ochar_next = pre_reg[2*CHAR_W-1 -: CHAR_W];
                        olast_next = 1'b0;
                        pre_next   = {pre_reg[CHAR_W-1:0], {CHAR_W{1'b0}}};
                        pre_n_next = pre_n_reg - 1'b1;
                    end
                    else
                    begin
                        ochar_next  = nibble_to_ascii(digits_reg[VALUE_W-1 -: 4]);
                        olast_next  = (ndig_reg == NDIG_W'(1));
                        digits_next = {digits_reg[VALUE_W-5:0], 4'd0};
                        ndig_next   = ndig_reg - 1'b1;
                        if (ndig_reg == NDIG_W'(1))
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
            count_reg  <= '0;
            pre_n_reg  <= '0;
            ndig_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            count_reg  <= count_next;
            pre_n_reg  <= pre_n_next;
            ndig_reg   <= ndig_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        digits_reg <= digits_next;
        pre_reg    <= pre_next;
        ochar_reg  <= ochar_next;
        olast_reg  <= olast_next;
    end

    // output packing
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tlast  = olast_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W-CHAR_W-COUNT_W){1'b0}}, count_reg, ochar_reg};

    // a character always carries a nonzero running count
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg |-> count_reg != '0)
        else $error("character with zero count");

    // no run exceeds the longest pointer string
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(HEX_DIGITS + 2))
        else $error("character count too large");

    // emitting always has a digit left
    a_emit_digits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> ndig_reg != '0)
        else $error("emit with no digits left");

    // trimming stops on a nonzero digit or the single last digit
    a_trim_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && $past(state_reg) == ST_TRIM) |->
            (ndig_reg == NDIG_W'(1) || digits_reg[VALUE_W-1 -: 4] != 4'd0))
        else $error("leading zero left after trim");

endmodule
